### sv/vu_bar_pkg.sv
package vu_bar_pkg;

    localparam int NUM_LEDS_DEF = 6;

    localparam int ADC_W      = 10;
    localparam int TIME_W     = 32;
    localparam int AMP_W      = 10;
    localparam int RANGE_W    = 11;
    localparam int TOP_W      = 3;
    localparam int MS_W       = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_FIELD_W = ADC_W + TIME_W;
    localparam int IN_TDATA_W = ((IN_FIELD_W + 7) / 8) * 8;

    localparam logic [ADC_W-1:0]   ADC_FULL      = 10'd1023;
    localparam logic [RANGE_W-1:0] RANGE_LOW_RST = 11'd1023;
    localparam logic [TOP_W-1:0]   GREEN_TOP_RST = 3'd3;
    localparam logic [TOP_W-1:0]   YELLOW_TOP_RST = 3'd5;
    localparam logic [MS_W-1:0]    HOLD_MS_RST   = 16'd600;
    localparam logic [MS_W-1:0]    STEP_MS_RST   = 16'd50;
    localparam logic [7:0]         DARKEN_BY     = 8'd128;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GREEN_TOP  = 2'd0,
        REG_YELLOW_TOP = 2'd1,
        REG_HOLD_MS    = 2'd2,
        REG_STEP_MS    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
    } pixel_t;

    localparam pixel_t PIX_OFF    = '{red: 8'd0,   green: 8'd0,   blue: 8'd0, white: 8'd0};
    localparam pixel_t PIX_WHITE  = '{red: 8'd0,   green: 8'd0,   blue: 8'd0, white: 8'd255};
    localparam pixel_t PIX_GREEN  = '{red: 8'd0,   green: 8'd255, blue: 8'd0, white: 8'd0};
    localparam pixel_t PIX_YELLOW = '{red: 8'd255, green: 8'd255, blue: 8'd0, white: 8'd0};

    function automatic logic [7:0] sat_sub(input logic [7:0] ch);
        return (ch > DARKEN_BY) ? ch - DARKEN_BY : 8'd0;
    endfunction

    function automatic pixel_t darken(input pixel_t c);
        pixel_t d;
        d.red   = sat_sub(c.red);
        d.green = sat_sub(c.green);
        d.blue  = sat_sub(c.blue);
        d.white = sat_sub(c.white);
        return d;
    endfunction

endpackage

### sv/vu_meter_peak_hold_bar.sv
// Channel  | Direction | Sideband    | tdata fields (lowest bit first)
// s_       | in        | tuser=func  | adc_sample, now_ms
// m_       | out       | tlast=last  | led_index, red, green, blue, white, level,
//          |           |             | peak_level, amplitude
// cfg_     | in        | -           | cfg_wdata holds the register value
//
// Samples may arrive on every cycle while s_tready is high.
// An end-of-window transfer passes a preparation step, the repeated-subtraction
// level divider, and the peak-hold and decay steps; then each pixel passes the
// read, modify and write-back of the pixel colour memory and any output stall.
// Reset is synchronous; the pixel memory reads as off until each entry is
// written, through one valid bit per LED, so no clearing pass is needed.
// s_tready is low from an end-of-window transfer until its last pixel is taken.
module vu_meter_peak_hold_bar
    import vu_bar_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // adc_sample, now_ms
    input  logic [IN_TDATA_W-1:0] s_tdata,
    // func
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // led_index, red, green, blue, white, level, peak_level, amplitude
    output logic [((((NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1)
                   + 2 * $clog2(NUM_LEDS + 1) + 42 + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                  m_tlast
);

    localparam int IDX_W      = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int LEVEL_W    = $clog2(NUM_LEDS + 1);
    localparam int CMP_W      = (LEVEL_W > TOP_W) ? LEVEL_W : TOP_W;
    localparam int NUM_W      = AMP_W + LEVEL_W;
    localparam int OUT_W      = IDX_W + 32 + 2 * LEVEL_W + AMP_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_HOLD,
        ST_DECAY,
        ST_READ,
        ST_PIXEL,
        ST_SEND
    } state_t;

    state_t state_reg;

    logic [TOP_W-1:0]   green_top_reg;
    logic [TOP_W-1:0]   yellow_top_reg;
    logic [MS_W-1:0]    hold_ms_reg;
    logic [MS_W-1:0]    step_ms_reg;

    logic [ADC_W-1:0]   win_min_reg;
    logic [ADC_W-1:0]   win_max_reg;
    logic [RANGE_W-1:0] range_low_reg;
    logic [RANGE_W-1:0] range_high_reg;
    logic [LEVEL_W-1:0] held_reg;
    logic [TIME_W-1:0]  hold_start_reg;
    logic [TIME_W-1:0]  decay_start_reg;

    logic [TIME_W-1:0]  now_reg;
    logic [AMP_W-1:0]   amp_reg;
    logic [NUM_W-1:0]   rem_reg;
    logic [RANGE_W-1:0] dvs_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [MS_W-1:0]    thr_reg;
    logic [IDX_W-1:0]   idx_reg;

    pixel_t             pix_mem [NUM_LEDS];
    logic [NUM_LEDS-1:0] pix_vld_reg;
    pixel_t             rd_pix_reg;
    logic               rd_vld_reg;

    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tvalid_reg;
    logic                   m_tlast_reg;

    logic [ADC_W-1:0]   smp;
    logic [TIME_W-1:0]  now_in;
    logic [ADC_W-1:0]   amp_next;
    logic [RANGE_W-1:0] amp_w;

    logic [RANGE_W:0]   rl_plus1;
    logic [RANGE_W:0]   rh_ext;
    logic               div_zero;
    logic               div_neg;
    logic [RANGE_W:0]   div_mag;
    logic               num_neg;
    logic [NUM_W-1:0]   num_mag;

    logic [TIME_W-1:0]  hold_elapsed;
    logic [TIME_W-1:0]  decay_elapsed;

    logic [CMP_W-1:0]   jx;
    logic [CMP_W-1:0]   heldx;
    logic [CMP_W-1:0]   levelx;
    pixel_t             pix_in;
    pixel_t             pix_next;
    logic               pix_we;

    assign smp    = s_tdata[ADC_W-1:0];
    assign now_in = s_tdata[IN_FIELD_W-1:ADC_W];

    assign amp_next = (win_max_reg >= win_min_reg) ? win_max_reg - win_min_reg : '0;
    assign amp_w    = RANGE_W'(amp_next);

    assign rl_plus1 = {1'b0, range_low_reg} + (RANGE_W + 1)'(1);
    assign rh_ext   = {1'b0, range_high_reg};
    assign div_zero = (rh_ext == rl_plus1);
    assign div_neg  = (rh_ext < rl_plus1);
    assign div_mag  = div_neg ? rl_plus1 - rh_ext : rh_ext - rl_plus1;
    assign num_neg  = (amp_reg == '0);
    assign num_mag  = num_neg ? NUM_W'(NUM_LEDS)
                              : NUM_W'(amp_reg - AMP_W'(1)) * NUM_W'(NUM_LEDS);

    assign hold_elapsed  = now_reg - hold_start_reg;
    assign decay_elapsed = now_reg - decay_start_reg;

    assign jx     = CMP_W'(idx_reg);
    assign heldx  = CMP_W'(held_reg);
    assign levelx = CMP_W'(level_reg);
    assign pix_in = rd_vld_reg ? rd_pix_reg : PIX_OFF;
    assign pix_we = (state_reg == ST_PIXEL);

    always_comb begin
        if (heldx != '0 && jx == heldx - CMP_W'(1)) begin
            pix_next = PIX_WHITE;
        end else if (jx >= heldx) begin
            pix_next = darken(pix_in);
        end else if (jx < levelx) begin
            if (jx < CMP_W'(green_top_reg)) begin
                pix_next = PIX_GREEN;
            end else if (jx < CMP_W'(yellow_top_reg)) begin
                pix_next = PIX_YELLOW;
            end else begin
                pix_next = darken(pix_in);
            end
        end else begin
            pix_next = darken(pix_in);
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_we) begin
            pix_mem[idx_reg] <= pix_next;
        end
        rd_pix_reg <= pix_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            green_top_reg   <= GREEN_TOP_RST;
            yellow_top_reg  <= YELLOW_TOP_RST;
            hold_ms_reg     <= HOLD_MS_RST;
            step_ms_reg     <= STEP_MS_RST;
            win_min_reg     <= ADC_FULL;
            win_max_reg     <= '0;
            range_low_reg   <= RANGE_LOW_RST;
            range_high_reg  <= '0;
            held_reg        <= '0;
            hold_start_reg  <= '0;
            decay_start_reg <= '0;
            pix_vld_reg     <= '0;
            rd_vld_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            m_tlast_reg     <= 1'b0;
            idx_reg         <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_GREEN_TOP:  green_top_reg  <= cfg_wdata[TOP_W-1:0];
                    REG_YELLOW_TOP: yellow_top_reg <= cfg_wdata[TOP_W-1:0];
                    REG_HOLD_MS:    hold_ms_reg    <= cfg_wdata[MS_W-1:0];
                    REG_STEP_MS:    step_ms_reg    <= cfg_wdata[MS_W-1:0];
                    default:        ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (!s_tuser) begin
                            if (smp > win_max_reg) begin
                                win_max_reg <= smp;
                            end else if (smp < win_min_reg) begin
                                win_min_reg <= smp;
                            end
                        end else begin
                            if (win_max_reg >= win_min_reg) begin
                                if (range_low_reg > amp_w) begin
                                    range_low_reg <= (amp_next != '0)
                                                     ? amp_w - RANGE_W'(1) : '0;
                                end
                                if (range_high_reg < amp_w) begin
                                    range_high_reg <= amp_w + RANGE_W'(1);
                                end
                            end
                            amp_reg     <= amp_next;
                            now_reg     <= now_in;
                            win_min_reg <= ADC_FULL;
                            win_max_reg <= '0;
                            state_reg   <= ST_PREP;
                        end
                    end
                end
                ST_PREP: begin
                    rem_reg   <= num_mag;
                    dvs_reg   <= RANGE_W'(div_mag);
                    level_reg <= '0;
                    if (div_zero || (num_neg != div_neg)) begin
                        state_reg <= ST_HOLD;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (rem_reg >= NUM_W'(dvs_reg) && level_reg != LEVEL_W'(NUM_LEDS)) begin
                        rem_reg   <= rem_reg - NUM_W'(dvs_reg);
                        level_reg <= level_reg + LEVEL_W'(1);
                    end else begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (level_reg >= held_reg) begin
                        held_reg       <= level_reg;
                        hold_start_reg <= now_reg;
                    end
                    thr_reg   <= (hold_ms_reg > step_ms_reg) ? hold_ms_reg - step_ms_reg : '0;
                    state_reg <= ST_DECAY;
                end
                ST_DECAY: begin
                    if (hold_elapsed >= TIME_W'(thr_reg) && held_reg != '0
                            && decay_elapsed >= TIME_W'(step_ms_reg)) begin
                        held_reg        <= held_reg - LEVEL_W'(1);
                        decay_start_reg <= now_reg;
                    end
                    idx_reg   <= '0;
                    state_reg <= ST_READ;
                end
                ST_READ: begin
                    rd_vld_reg <= pix_vld_reg[idx_reg];
                    state_reg  <= ST_PIXEL;
                end
                ST_PIXEL: begin
                    pix_vld_reg[idx_reg] <= 1'b1;
                    m_tdata_reg  <= OUT_TDATA_W'({amp_reg, held_reg, level_reg,
                                                  pix_next.white, pix_next.blue,
                                                  pix_next.green, pix_next.red, idx_reg});
                    m_tlast_reg  <= (idx_reg == IDX_W'(NUM_LEDS - 1));
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= ST_SEND;
                end
                ST_SEND: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (idx_reg == IDX_W'(NUM_LEDS - 1)) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= ST_READ;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### sim/vu_meter_peak_hold_bar_tb.sv
`timescale 1ns / 1ps

module vu_meter_peak_hold_bar_tb;
    import vu_bar_pkg::*;

    localparam int N_LEDS        = NUM_LEDS_DEF;
    localparam int IDX_W         = (N_LEDS > 1) ? $clog2(N_LEDS) : 1;
    localparam int LVL_W         = $clog2(N_LEDS + 1);
    localparam int M_FIELD_W     = IDX_W + 32 + 2 * LVL_W + AMP_W;
    localparam int M_TDATA_W     = ((M_FIELD_W + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_OFF_LEN  = 400;

    typedef struct {
        logic [IDX_W-1:0] led;
        pixel_t           colour;
        logic [LVL_W-1:0] lvl;
        logic [LVL_W-1:0] peak;
        logic [AMP_W-1:0] amp;
        logic             tail;
    } pixel_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    vu_meter_peak_hold_bar #(
        .NUM_LEDS(N_LEDS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Meter state as the block should hold it.
    logic [ADC_W-1:0] win_lo = ADC_FULL;
    logic [ADC_W-1:0] win_hi = '0;
    int               rng_lo = 1023;
    int               rng_hi = 0;
    int               held   = 0;
    logic [31:0]      hold_t0  = '0;
    logic [31:0]      decay_t0 = '0;
    pixel_t           led_colour [N_LEDS];
    logic [2:0]       lim_green   = GREEN_TOP_RST;
    logic [2:0]       lim_yellow  = YELLOW_TOP_RST;
    logic [15:0]      hold_period = HOLD_MS_RST;
    logic [15:0]      decay_step  = STEP_MS_RST;

    pixel_result_t expected_pixels [$];
    pixel_result_t want;
    int            n_errors      = 0;
    int            send_idle_pct = 0;
    int            stall_pct     = 0;
    int            hold_off_len  = 0;
    int            quiet_cycles  = 0;
    logic [31:0]   ms_now        = '0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic pixel_t fade_pixel(input pixel_t p);
        pixel_t f;
        f.red   = (p.red   > DARKEN_BY) ? p.red   - DARKEN_BY : 8'd0;
        f.green = (p.green > DARKEN_BY) ? p.green - DARKEN_BY : 8'd0;
        f.blue  = (p.blue  > DARKEN_BY) ? p.blue  - DARKEN_BY : 8'd0;
        f.white = (p.white > DARKEN_BY) ? p.white - DARKEN_BY : 8'd0;
        return f;
    endfunction

    // Applies one accepted item and, for an end-of-window item, queues the frame of pixels it produces.
    task automatic update_meter(input bit fn, input logic [ADC_W-1:0] smp,
                                input logic [31:0] t);
        int            amp;
        int            lvl;
        longint        num;
        longint        den;
        longint        q;
        logic [15:0]   thr;
        logic [31:0]   since_hold;
        logic [31:0]   since_decay;
        pixel_t        c;
        pixel_result_t r;
        if (!fn) begin
            if (smp > win_hi) begin
                win_hi = smp;
            end else if (smp < win_lo) begin
                win_lo = smp;
            end
        end else begin
            if (win_hi >= win_lo) begin
                amp = int'(win_hi) - int'(win_lo);
                if (rng_lo > amp) begin
                    rng_lo = (amp > 0) ? amp - 1 : 0;
                end
                if (rng_hi < amp) begin
                    rng_hi = amp + 1;
                end
            end else begin
                amp = 0;
            end
            win_lo = ADC_FULL;
            win_hi = '0;

            den = longint'(rng_hi) - longint'(rng_lo) - 1;
            num = (longint'(amp) - 1) * N_LEDS;
            q = (den == 0) ? 0 : num / den;
            if (q < 0) begin
                q = 0;
            end
            if (q > N_LEDS) begin
                q = N_LEDS;
            end
            lvl = int'(q);

            if (lvl >= held) begin
                held = lvl;
                hold_t0 = t;
            end
            thr = (hold_period > decay_step) ? hold_period - decay_step : 16'd0;
            since_hold = t - hold_t0;
            since_decay = t - decay_t0;
            if (since_hold >= {16'd0, thr} && held > 0) begin
                if (since_decay >= {16'd0, decay_step}) begin
                    held = held - 1;
                    decay_t0 = t;
                end
            end

            for (int j = 0; j < N_LEDS; j++) begin
                c = led_colour[j];
                if (held > 0 && j == held - 1) begin
                    c = PIX_WHITE;
                end else if (j >= held) begin
                    c = fade_pixel(c);
                end else if (j < lvl) begin
                    if (j < int'(lim_green)) begin
                        c = PIX_GREEN;
                    end else if (j < int'(lim_yellow)) begin
                        c = PIX_YELLOW;
                    end else begin
                        c = fade_pixel(c);
                    end
                end else begin
                    c = fade_pixel(c);
                end
                led_colour[j] = c;
                r.led    = IDX_W'(j);
                r.colour = c;
                r.lvl    = LVL_W'(lvl);
                r.peak   = LVL_W'(held);
                r.amp    = AMP_W'(amp);
                r.tail   = (j == N_LEDS - 1);
                expected_pixels.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint got,
                                   input longint exp_val);
        $display("ERROR: %s: got %0d, expected %0d at %0t", what, got, exp_val, $realtime);
        n_errors++;
    endtask

    task automatic send_item(input bit fn, input logic [ADC_W-1:0] smp,
                             input logic [31:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= IN_TDATA_W'({t, smp});
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        update_meter(fn, smp, t);
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes all four registers back to back once the block has gone quiet.
    task automatic apply_settings(input logic [2:0] g, input logic [2:0] y,
                                  input logic [15:0] h, input logic [15:0] s);
        cfg_reg_t    r;
        logic [15:0] v;
        drain_and_settle();
        for (int k = 0; k < 4; k++) begin
            r = cfg_reg_t'(k);
            case (r)
                REG_GREEN_TOP: begin
                    v = {13'($urandom), g};
                    lim_green = g;
                end
                REG_YELLOW_TOP: begin
                    v = {13'($urandom), y};
                    lim_yellow = y;
                end
                REG_HOLD_MS: begin
                    v = h;
                    hold_period = h;
                end
                default: begin
                    v = s;
                    decay_step = s;
                end
            endcase
            cfg_we    <= 1'b1;
            cfg_addr  <= r;
            cfg_wdata <= v;
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // Mostly whole windows of samples closed by an end-of-window item, with
    // some stray items and some windows that hold no samples at all.
    task automatic random_windows(input int n_items);
        int sent;
        int choice;
        int len;
        int centre;
        int spread;
        int s;
        sent = 0;
        while (sent < n_items) begin
            choice = $urandom_range(99);
            if (choice < 10) begin
                send_item(1'($urandom), 10'($urandom), $urandom);
                sent++;
            end else begin
                len = (choice < 18) ? 0 : $urandom_range(1, 8);
                centre = $urandom_range(1023);
                spread = ($urandom_range(3) == 0) ? 1023 : $urandom_range(0, 200);
                repeat (len) begin
                    s = centre - spread / 2 + int'($urandom_range(spread));
                    if (s < 0) begin
                        s = 0;
                    end
                    if (s > 1023) begin
                        s = 1023;
                    end
                    send_item(1'b0, 10'(s), $urandom);
                end
                if ($urandom_range(19) == 0) begin
                    ms_now = $urandom;
                end else begin
                    ms_now = ms_now + $urandom_range(0, 250);
                end
                send_item(1'b1, 10'($urandom), ms_now);
                sent += len + 1;
            end
        end
    endtask

    task automatic test_edge_cases();
        send_idle_pct = 0;
        stall_pct = 0;
        send_item(1'b1, 10'd0, 32'd0);
        send_item(1'b0, 10'd0, 32'hFFFF_FFFF);
        send_item(1'b1, 10'd1023, 32'd1);
        send_item(1'b0, 10'd1023, 32'd0);
        send_item(1'b0, 10'd0, 32'd0);
        send_item(1'b1, 10'd0, 32'hFFFF_FFFF);
        send_item(1'b0, 10'd512, 32'hAAAA_5555);
        send_item(1'b1, 10'd1023, 32'h0000_0100);
        send_item(1'b0, 10'd5, 32'd0);
        send_item(1'b0, 10'd5, 32'd0);
        send_item(1'b1, 10'd0, 32'h0000_0200);
        send_item(1'b0, 10'd300, 32'h5555_AAAA);
        send_item(1'b0, 10'd700, 32'd0);
        send_item(1'b0, 10'd1000, 32'd0);
        send_item(1'b1, 10'd0, 32'h0000_0500);
        send_item(1'b1, 10'd0, 32'h0000_0800);
        send_item(1'b0, 10'd1023, 32'd0);
        send_item(1'b0, 10'd1022, 32'd0);
        send_item(1'b1, 10'd0, 32'h0000_0900);
        ms_now = 32'h0000_0900;
    endtask

    task automatic test_low_extremes();
        apply_settings(3'd0, 3'd0, 16'd0, 16'd1);
        send_idle_pct = 0;
        stall_pct = 0;
        random_windows(60);
    endtask

    task automatic test_sender_gaps();
        apply_settings(3'd7, 3'd7, 16'hFFFF, 16'hFFFF);
        send_idle_pct = 83;
        stall_pct = 0;
        random_windows(60);
    endtask

    task automatic test_receiver_stalls();
        apply_settings(3'd2, 3'd4, 16'd100, 16'd200);
        send_idle_pct = 0;
        stall_pct = 83;
        random_windows(70);
    endtask

    task automatic test_mixed_idling();
        apply_settings(3'd3, 3'd6, 16'd600, 16'd0);
        send_idle_pct = 22;
        stall_pct = 22;
        random_windows(70);
    endtask

    task automatic test_backpressure();
        apply_settings(3'd4, 3'd5, 16'd300, 16'd20);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_len = HOLD_OFF_LEN;
        random_windows(40);
        drain_and_settle();
        send_idle_pct = 22;
        stall_pct = 22;
        random_windows(20);
    endtask

    initial begin
        for (int j = 0; j < N_LEDS; j++) begin
            led_colour[j] = PIX_OFF;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edge_cases();
        test_low_extremes();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        test_backpressure();
        drain_and_settle();
        if (n_errors == 0) begin
            $display("vu_meter_peak_hold_bar verification clean");
        end else begin
            $display("vu_meter_peak_hold_bar verification failed");
        end
        $finish;
    end

    // Result side: random stalls, or one long hold-off when one is requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_len != 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_len) @(posedge aclk);
                hold_off_len = 0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("pixel transfer with nothing pending, led_index",
                                m_tdata[IDX_W-1:0], -1);
            end else begin
                want = expected_pixels.pop_front();
                if (m_tdata[IDX_W-1:0] !== want.led)
                    report_mismatch("led_index", m_tdata[IDX_W-1:0], want.led);
                if (m_tdata[IDX_W +: 8] !== want.colour.red)
                    report_mismatch("red", m_tdata[IDX_W +: 8], want.colour.red);
                if (m_tdata[IDX_W + 8 +: 8] !== want.colour.green)
                    report_mismatch("green", m_tdata[IDX_W + 8 +: 8], want.colour.green);
                if (m_tdata[IDX_W + 16 +: 8] !== want.colour.blue)
                    report_mismatch("blue", m_tdata[IDX_W + 16 +: 8], want.colour.blue);
                if (m_tdata[IDX_W + 24 +: 8] !== want.colour.white)
                    report_mismatch("white", m_tdata[IDX_W + 24 +: 8], want.colour.white);
                if (m_tdata[IDX_W + 32 +: LVL_W] !== want.lvl)
                    report_mismatch("level", m_tdata[IDX_W + 32 +: LVL_W], want.lvl);
                if (m_tdata[IDX_W + 32 + LVL_W +: LVL_W] !== want.peak)
                    report_mismatch("peak_level", m_tdata[IDX_W + 32 + LVL_W +: LVL_W],
                                    want.peak);
                if (m_tdata[IDX_W + 32 + 2 * LVL_W +: AMP_W] !== want.amp)
                    report_mismatch("amplitude", m_tdata[IDX_W + 32 + 2 * LVL_W +: AMP_W],
                                    want.amp);
                if (m_tdata[M_TDATA_W-1:M_FIELD_W] !== '0)
                    report_mismatch("tdata padding", m_tdata[M_TDATA_W-1:M_FIELD_W], 0);
                if (m_tlast !== want.tail)
                    report_mismatch("tlast", m_tlast, want.tail);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("vu_meter_peak_hold_bar verification failed");
            $finish;
        end
    end

endmodule
